[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[src/rct_pkg.sv]
// ----------------------------------------------------------------------------
// rct_pkg
// Shared widths, operation codes and control structs of the remote code table.
// ----------------------------------------------------------------------------
package rct_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned ID_W    = 64;
  localparam int unsigned ACT_W   = 4;
  localparam int unsigned ENTRY_W = ID_W + ACT_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2,
    OP_NEXT   = 2'd3
  } rct_op_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture request, rewind scan
    logic scan;      // issue read of current slot, advance
    logic commit;    // apply table update
    logic rsp_load;  // load result into output register
  } rct_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_last; // current read address is the last slot
  } rct_sts_t;

endpackage

[src/rct_if.sv]
// ----------------------------------------------------------------------------
// rct_if
// Valid/ready channels for requests and results of the remote code table.
// ----------------------------------------------------------------------------
interface rct_req_if import rct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    req_type;
  logic [ID_W-1:0]    rf_code;
  logic [ACT_W-1:0]   action_code;

  modport source (output valid, output req_type, output rf_code, output action_code,
                  input ready);
  modport sink   (input valid, input req_type, input rf_code, input action_code,
                  output ready);
endinterface

interface rct_rsp_if import rct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [ID_W-1:0]    next_code;

  modport source (output valid, output hit, output next_code, input ready);
  modport sink   (input valid, input hit, input next_code, output ready);
endinterface

[src/rct_ram.sv]
// ----------------------------------------------------------------------------
// rct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/rct_ctrl.sv]
// ----------------------------------------------------------------------------
// rct_ctrl
// Request sequencer: accept, scan all slots, drain, commit, hand over result.
// ----------------------------------------------------------------------------
module rct_ctrl import rct_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output rct_cmd_t cmd_o,
  input  rct_sts_t sts_i
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_COMMIT = 5'b01000,
    ST_WAIT   = 5'b10000
  } rct_state_e;

  rct_state_e state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       out_free;

  // Output register may take a result when empty or being drained
  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;

  // Decode commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && req_valid_i;
    cmd_o.scan     = (state_q == ST_SCAN);
    cmd_o.commit   = (state_q == ST_COMMIT);
    cmd_o.rsp_load = ((state_q == ST_COMMIT) || (state_q == ST_WAIT)) && out_free;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (req_valid_i) state_d = ST_SCAN;
      ST_SCAN:   if (sts_i.scan_last) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_COMMIT;
      ST_COMMIT: state_d = out_free ? ST_IDLE : ST_WAIT;
      ST_WAIT:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Output valid: set on load, drop once taken, otherwise hold
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    priority if (cmd_o.rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule

[src/rct_dp.sv]
// ----------------------------------------------------------------------------
// rct_dp
// Datapath: request capture, slot scan trackers, valid bits, table update and
// result register.
// ----------------------------------------------------------------------------
module rct_dp import rct_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16,
  localparam int unsigned AW       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rct_cmd_t           cmd_i,
  output rct_sts_t           sts_o,
  // request payload
  input  logic [OP_W-1:0]    req_type_i,
  input  logic [ID_W-1:0]    rf_code_i,
  input  logic [ACT_W-1:0]   action_code_i,
  // table RAM
  output logic               ram_we_o,
  output logic [AW-1:0]      ram_waddr_o,
  output logic [ENTRY_W-1:0] ram_wdata_o,
  output logic [AW-1:0]      ram_raddr_o,
  input  logic [ENTRY_W-1:0] ram_rdata_i,
  // result payload
  output logic               hit_o,
  output logic [ID_W-1:0]    next_code_o
);

  localparam logic [AW-1:0] LastSlot = AW'(NUM_SLOTS - 1);

  // Captured request
  rct_op_e          op_q;
  logic [ID_W-1:0]  code_q;
  logic [ACT_W-1:0] act_q;

  // Scan address and read pipeline
  logic [AW-1:0]    addr_q;
  logic [AW-1:0]    rd_idx_q;
  logic             rd_vld_q;
  logic             rd_slot_vld_q;
  logic [ID_W-1:0]  rd_id;

  // Valid bits: an entry not valid reads as a free slot
  logic [NUM_SLOTS-1:0] slot_vld_q;

  // Trackers
  logic             free_found_q;
  logic [AW-1:0]    free_idx_q;
  logic             match_found_q;
  logic [AW-1:0]    match_idx_q;
  logic [ID_W-1:0]  cand_q;      // first nonzero id after latest match
  logic [ID_W-1:0]  first_nz_q;  // first nonzero id overall

  logic             id_is_code;
  logic             id_is_zero;
  logic             hit_d;
  logic [ID_W-1:0]  next_d;

  assign sts_o.scan_last = (addr_q == LastSlot);
  assign ram_raddr_o     = addr_q;

  // Capture request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= rct_op_e'(req_type_i);
      code_q <= rf_code_i;
      act_q  <= action_code_i;
    end
  end

  // Advance scan address, track the slot the read data belongs to
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.load) begin
        addr_q <= '0;
      end else if (cmd_i.scan) begin
        addr_q <= addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q      <= addr_q;
    rd_slot_vld_q <= slot_vld_q[addr_q];
  end

  assign rd_id      = rd_slot_vld_q ? ram_rdata_i[ID_W-1:0] : '0;
  assign id_is_code = (rd_id == code_q);
  assign id_is_zero = (rd_id == '0);

  // Update trackers on each returned slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
      match_found_q <= 1'b0;
      match_idx_q   <= '0;
      cand_q        <= '0;
      first_nz_q    <= '0;
    end else if (rd_vld_q) begin
      if (id_is_zero && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= rd_idx_q;
      end
      if (id_is_code && !match_found_q) begin
        match_found_q <= 1'b1;
        match_idx_q   <= rd_idx_q;
      end
      priority if (id_is_code) begin
        cand_q <= '0;
      end else if (!id_is_zero && (cand_q == '0)) begin
        cand_q <= rd_id;
      end else begin
        cand_q <= cand_q;
      end
      if (!id_is_zero && (first_nz_q == '0)) begin
        first_nz_q <= rd_id;
      end
    end
  end

  // Apply table update: add writes the entry, remove frees it
  assign ram_we_o    = cmd_i.commit && (op_q == OP_ADD) && free_found_q;
  assign ram_waddr_o = free_idx_q;
  assign ram_wdata_o = {act_q, code_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
    end else if (cmd_i.commit) begin
      if ((op_q == OP_ADD) && free_found_q) begin
        slot_vld_q[free_idx_q] <= 1'b1;
      end else if ((op_q == OP_REMOVE) && match_found_q) begin
        slot_vld_q[match_idx_q] <= 1'b0;
      end
    end
  end

  // Form result
  always_comb begin
    hit_d  = 1'b0;
    next_d = '0;
    unique case (op_q)
      OP_ADD:    hit_d = free_found_q;
      OP_REMOVE: hit_d = 1'b0;
      OP_CHECK:  hit_d = match_found_q;
      OP_NEXT:   next_d = ((code_q != '0) && match_found_q) ? cand_q : first_nz_q;
      default:   hit_d = 1'b0;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_load) begin
      hit_o       <= hit_d;
      next_code_o <= next_d;
    end
  end

endmodule

[src/remote_code_table.sv]
// ----------------------------------------------------------------------------
// remote_code_table
// Table of radio remote codes with add, remove, check and next operations.
// ----------------------------------------------------------------------------
// Each request returns one result. The table lives in a RAM with one read
// port; every request reads all NUM_SLOTS slots, one per cycle, then handles
// the last read data in a drain state and applies the update in a commit
// state, which also loads the output register. No new request is accepted
// before the current one has been committed. A new request is accepted even
// while the previous result still waits in the output register, but its own
// result is loaded only once that register is free, and the sequencer holds
// off further requests until then. Reset clears the table at once through
// per-slot valid bits; no clearing pass is needed.
module remote_code_table import rct_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rct_req_if.sink   req_i,
  rct_rsp_if.source rsp_o
);

  localparam int unsigned AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  rct_cmd_t           cmd;
  rct_sts_t           sts;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // Sequencer
  rct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath
  rct_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_i.req_type),
    .rf_code_i     (req_i.rf_code),
    .action_code_i (req_i.action_code),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .hit_o         (rsp_o.hit),
    .next_code_o   (rsp_o.next_code)
  );

  // Slot store: id and action per slot
  rct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Checks on the sequencing
  `include "assert_macros.svh"

  `ASSERT_NEVER(a_accept_during_scan, req_i.ready && cmd.scan, "request taken mid-scan")
  `ASSERT_PROP(a_scan_stops, (cmd.scan && sts.scan_last) |=> !cmd.scan, "scan overran table")
  `ASSERT_PROP(a_rsp_loaded, cmd.rsp_load |=> rsp_o.valid, "loaded result not presented")

endmodule

[test/remote_code_table_test.sv]
// ----------------------------------------------------------------------------
// remote_code_table_test
// Self-checking testbench for the remote code table. A scoreboard keeps its
// own copy of the sixteen slots and predicts the result of every accepted
// request. A short directed run covers the empty and full table and the
// code-zero cases. A long random run follows, with fill and drain phases and
// codes taken from the live table, a pool, zero or fresh. Request bursts and
// result stalls are random.
// ----------------------------------------------------------------------------
module remote_code_table_test;
  import rct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned RAND_ITEMS  = 1350;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned TAIL_CYCLES = 40;

  // Predicted result of one request
  typedef struct {
    bit            hit;
    bit [ID_W-1:0] next_code;
  } code_result_t;

  // Table predictor and queue of expected results
  class rct_scoreboard;
    bit [ID_W-1:0]  slot_code[SLOTS];
    bit [ACT_W-1:0] slot_act[SLOTS];
    code_result_t   expected_q[$];
    int unsigned    errors;

    function new();
      foreach (slot_code[k]) begin
        slot_code[k] = '0;
        slot_act[k]  = '0;
      end
      errors = 0;
    endfunction

    // Lowest slot holding code, or SLOTS when absent
    function int unsigned lowest_match(bit [ID_W-1:0] code);
      for (int unsigned k = 0; k < SLOTS; k++) begin
        if (slot_code[k] == code) return k;
      end
      return SLOTS;
    endfunction

    // Apply an accepted request to the table and queue its result
    function void note_request(rct_op_e op, bit [ID_W-1:0] code, bit [ACT_W-1:0] act);
      code_result_t res;
      int unsigned  k;
      int unsigned  start;
      res.hit       = 1'b0;
      res.next_code = '0;
      case (op)
        OP_ADD: begin
          k = lowest_match('0);
          if (k < SLOTS) begin
            slot_code[k] = code;
            slot_act[k]  = act;
            res.hit      = 1'b1;
          end
        end
        OP_REMOVE: begin
          k = lowest_match(code);
          if (k < SLOTS) begin
            slot_code[k] = '0;
            slot_act[k]  = '0;
          end
        end
        OP_CHECK: begin
          res.hit = (lowest_match(code) < SLOTS);
        end
        default: begin
          // Scan from just past the highest slot holding the code
          start = 0;
          if (code != '0) begin
            for (k = 0; k < SLOTS; k++) begin
              if (slot_code[k] == code) start = k + 1;
            end
          end
          for (k = start; k < SLOTS; k++) begin
            if (slot_code[k] != '0) begin
              res.next_code = slot_code[k];
              break;
            end
          end
        end
      endcase
      expected_q.push_back(res);
    endfunction

    // Compare a result transaction with the oldest expectation
    function void check_result(bit hit, bit [ID_W-1:0] next_code);
      code_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: hit %0d next_code %h", hit, next_code);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (hit != want.hit) begin
        $error("hit mismatch: expected %0d, actual %0d", want.hit, hit);
        errors++;
      end
      if (next_code != want.next_code) begin
        $error("next_code mismatch: expected %h, actual %h", want.next_code, next_code);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  rct_req_if req_if ();
  rct_rsp_if rsp_if ();

  remote_code_table #(
    .NUM_SLOTS (SLOTS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  rct_scoreboard codes_sb;

  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned stall_left;
  int unsigned stall_level;
  bit [ID_W-1:0] code_pool[12];

  // Free-running clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Known values on every input from time zero
  initial begin
    codes_sb           = new();
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.req_type    = OP_ADD;
    req_if.rf_code     = '0;
    req_if.action_code = '0;
    rsp_if.ready       = 1'b0;
    cycle_count        = 0;
    burst_left         = 0;
    stall_left         = 0;
    stall_level        = 0;
  end

  // Hard stop on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result stalls: segments of always ready, mostly ready, mostly stalled, stalled
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_left  = $urandom_range(1, 40);
      stall_level = $urandom_range(0, 3);
    end
    stall_left--;
    case (stall_level)
      0:       rsp_if.ready <= 1'b1;
      1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
      2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
      default: rsp_if.ready <= 1'b0;
    endcase
  end

  // Check every result transaction
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      codes_sb.check_result(rsp_if.hit, rsp_if.next_code);
    end
  end

  function automatic bit [ID_W-1:0] rand_code();
    return {$urandom(), $urandom()};
  endfunction

  // Present one request and hold it until accepted
  task automatic send_request(rct_op_e op, bit [ID_W-1:0] code, bit [ACT_W-1:0] act);
    @(negedge clk_i);
    req_if.valid       <= 1'b1;
    req_if.req_type    <= op;
    req_if.rf_code     <= code;
    req_if.action_code <= act;
    do @(posedge clk_i); while (!req_if.ready);
    codes_sb.note_request(op, code, act);
  endtask

  // Drop valid for a number of cycles
  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
  endtask

  // Send within random bursts separated by random gaps
  task automatic send_bursty(rct_op_e op, bit [ID_W-1:0] code, bit [ACT_W-1:0] act);
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) idle_cycles($urandom_range(5, 25));
      else idle_cycles($urandom_range(0, 3));
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    send_request(op, code, act);
  endtask

  // Hold off until every expected result has come
  task automatic drain_results();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (codes_sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Pick a code: half from the table for non-adds, else pool, zero or fresh
  function automatic bit [ID_W-1:0] pick_code(bit for_add);
    int unsigned r;
    int unsigned idx;
    r = $urandom_range(0, 99);
    if (for_add) begin
      if (r < 70) return code_pool[$urandom_range(0, 11)];
      if (r < 75) return '0;
      idx = $urandom_range(0, 11);
      code_pool[idx] = rand_code();
      return code_pool[idx];
    end
    if (r < 50) return codes_sb.slot_code[$urandom_range(0, SLOTS - 1)];
    if (r < 75) return code_pool[$urandom_range(0, 11)];
    if (r < 85) return '0;
    return rand_code();
  endfunction

  initial begin : stimulus
    rct_op_e       op;
    bit [ID_W-1:0] code;
    int unsigned   r;
    int unsigned   phase_left;
    bit            filling;

    foreach (code_pool[k]) code_pool[k] = rand_code();
    code_pool[0] = '1;

    // Hold reset, then release away from the rising edge
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty table: check and next of code zero, add and remove of code zero
    send_request(OP_CHECK, '0, 4'h0);
    send_request(OP_NEXT, '0, 4'h0);
    send_request(OP_ADD, '0, 4'hF);
    send_request(OP_REMOVE, '0, 4'h0);

    // Fill every slot, extremes first
    send_request(OP_ADD, '1, 4'hF);
    send_request(OP_ADD, 64'd1, 4'h0);
    send_request(OP_ADD, 64'h8000_0000_0000_0000, 4'h5);
    send_request(OP_ADD, 64'h5555_5555_5555_5555, 4'hA);
    for (int unsigned k = 4; k < SLOTS; k++) begin
      send_request(OP_ADD, rand_code(), 4'($urandom()));
    end

    // Full table: add fails, no free slot for code zero
    send_request(OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 4'h3);
    send_request(OP_CHECK, '0, 4'h0);
    // Next from a middle slot, from the last slot, from an unknown code
    send_request(OP_NEXT, codes_sb.slot_code[7], 4'h0);
    send_request(OP_NEXT, codes_sb.slot_code[SLOTS - 1], 4'h0);
    send_request(OP_NEXT, 64'hAAAA_AAAA_AAAA_AAAA, 4'h0);
    send_request(OP_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA, 4'h0);
    drain_results();

    // Random part: alternate fill and drain phases
    filling    = 1'b0;
    phase_left = 0;
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(40, 80);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (filling) begin
        if (r < 50) op = OP_ADD;
        else if (r < 60) op = OP_REMOVE;
        else if (r < 80) op = OP_CHECK;
        else op = OP_NEXT;
      end else begin
        if (r < 10) op = OP_ADD;
        else if (r < 60) op = OP_REMOVE;
        else if (r < 80) op = OP_CHECK;
        else op = OP_NEXT;
      end
      code = pick_code(op == OP_ADD);
      send_bursty(op, code, 4'($urandom()));
      if ((n % 450) == 449) drain_results();
    end

    // Wait for the last results, then a short tail
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (codes_sb.errors == 0 && codes_sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[remote_code_table.f]
+incdir+src
src/rct_pkg.sv
src/rct_if.sv
src/rct_ram.sv
src/rct_ctrl.sv
src/rct_dp.sv
src/remote_code_table.sv
test/remote_code_table_test.sv
